### rtl/core/sliding_window_peak_spread_top_defines.svh
// Assertion macros for the sliding window peak spread block
`ifndef SLIDING_WINDOW_PEAK_SPREAD_TOP_DEFINES_SVH
`define SLIDING_WINDOW_PEAK_SPREAD_TOP_DEFINES_SVH

// same-cycle implication on clk, off during reset
`define SWPS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication on clk, off during reset
`define SWPS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/swps_pkg.sv
// Types and constants shared by the sliding window peak spread block
`default_nettype none
package swps_pkg;

	localparam int FIELD_BITS = 16;
	localparam int IDX_BITS   = 16;
	localparam int SPAN_BITS  = 6;
	localparam logic [SPAN_BITS-1:0] SPAN_RESET = 6'd1;

	typedef struct packed {
		logic [FIELD_BITS-1:0] sample;
		logic                  restart;
	} in_t;

	typedef struct packed {
		logic [FIELD_BITS-1:0] best_spread;
		logic [FIELD_BITS-1:0] current_spread;
		logic                  window_full;
	} out_t;

	typedef struct packed {
		logic idle;
		logic done;
	} stat_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EXP_RD,
		ST_EXP_CMP,
		ST_POP_RD,
		ST_POP_CMP,
		ST_PUSH,
		ST_FRONT_RD,
		ST_SPREAD,
		ST_DONE
	} state_t;

endpackage
`default_nettype wire

### rtl/core/sliding_window_peak_spread_top.sv
// Sliding window peak spread: top level with config register and output register
//
// channel | dir | handshake           | payload
// in      | in  | in_valid/in_ready   | in_data  (swps_pkg::in_t)
// out     | out | out_valid/out_ready | out_data (swps_pkg::out_t)
// cfg     | in  | cfg_we              | cfg_wdata (window span)
//
// One item at a time: accept, then per queue expiry read/compare steps from the head,
// pop read/compare steps from the tail that drop entries, and a push; then the
// front read of both queues, spread and hand-off, one step after another as set by
// the single read port of each queue memory and the one shared subtract/compare unit.
// Reset clears queue pointers, counts, sample counter and best spread, not the memories.
// A waiting result stalls the next item only at hand-off, while the output register is full.
`default_nettype none
module sliding_window_peak_spread_top #(
	parameter int WINDOW_DEPTH = 64,
	parameter int SAMPLE_BITS  = 16
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire swps_pkg::in_t                  in_data,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output swps_pkg::out_t                      out_data,
	input  wire logic                           cfg_we,
	input  wire logic [swps_pkg::SPAN_BITS-1:0] cfg_wdata
);

	localparam int AW = $clog2(WINDOW_DEPTH);
	localparam int VW = (SAMPLE_BITS < swps_pkg::FIELD_BITS) ? SAMPLE_BITS
		: swps_pkg::FIELD_BITS;
	localparam int DW = swps_pkg::IDX_BITS + VW;

	logic [swps_pkg::SPAN_BITS-1:0] span_q;
	logic                           out_valid_q;
	swps_pkg::out_t                 out_q;
	logic                           out_free;
	logic                           start;
	swps_pkg::stat_t                stat;
	swps_pkg::out_t                 result;
	logic [1:0]                     mem_we;
	logic [AW-1:0]                  mem_waddr;
	logic [DW-1:0]                  mem_wdata;
	logic [AW-1:0]                  mem_raddr [2];
	logic [DW-1:0]                  mem_rdata [2];

	assign out_free  = ~out_valid_q | out_ready;
	assign in_ready  = stat.idle;
	assign start     = in_valid & stat.idle;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			span_q      <= swps_pkg::SPAN_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				span_q <= cfg_wdata;
			end
			if (stat.done) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (stat.done) begin
			out_q <= result;
		end
	end

	swps_ctrl #(
		.WINDOW_DEPTH(WINDOW_DEPTH),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.item     (in_data),
		.span     (span_q),
		.out_free (out_free),
		.stat     (stat),
		.result   (result),
		.mem_we   (mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata)
	);

	swps_qram #(
		.DEPTH(WINDOW_DEPTH),
		.DW   (DW)
	) u_min_ram (
		.clk  (clk),
		.we   (mem_we[0]),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr[0]),
		.rdata(mem_rdata[0])
	);

	swps_qram #(
		.DEPTH(WINDOW_DEPTH),
		.DW   (DW)
	) u_max_ram (
		.clk  (clk),
		.we   (mem_we[1]),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr[1]),
		.rdata(mem_rdata[1])
	);

endmodule
`default_nettype wire

### rtl/core/swps_qram.sv
// Queue entry memory: one write port, one registered read port
`default_nettype none
module swps_qram #(
	parameter int DEPTH = 64,
	parameter int DW    = 32,
	localparam int AW   = $clog2(DEPTH)
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [DW-1:0] wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

### rtl/core/swps_ctrl.sv
// Sequencer and shared subtract/compare unit for both monotonic queues
`default_nettype none
`include "sliding_window_peak_spread_top_defines.svh"
module swps_ctrl #(
	parameter int WINDOW_DEPTH = 64,
	parameter int SAMPLE_BITS  = 16,
	localparam int AW = $clog2(WINDOW_DEPTH),
	localparam int VW = (SAMPLE_BITS < swps_pkg::FIELD_BITS) ? SAMPLE_BITS
		: swps_pkg::FIELD_BITS,
	localparam int DW = swps_pkg::IDX_BITS + VW
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	input  wire swps_pkg::in_t                    item,
	input  wire logic [swps_pkg::SPAN_BITS-1:0]   span,
	input  wire logic                             out_free,
	output swps_pkg::stat_t                       stat,
	output swps_pkg::out_t                        result,
	output logic      [1:0]                       mem_we,
	output logic      [AW-1:0]                    mem_waddr,
	output logic      [DW-1:0]                    mem_wdata,
	output logic      [AW-1:0]                    mem_raddr [2],
	input  wire logic [DW-1:0]                    mem_rdata [2]
);

	localparam int CW = $clog2(WINDOW_DEPTH + 1);
	localparam int IW = swps_pkg::IDX_BITS;
	localparam int FW = swps_pkg::FIELD_BITS;

	swps_pkg::state_t state_q, state_d;
	logic             sel_q, sel_d;
	logic [AW-1:0]    head_q [2];
	logic [AW-1:0]    head_d [2];
	logic [CW-1:0]    count_q [2];
	logic [CW-1:0]    count_d [2];
	logic [IW-1:0]    counter_q, counter_d;
	logic             wrapped_q, wrapped_d;
	logic [VW-1:0]    best_q, best_d;
	logic [VW-1:0]    spread_q;
	logic             full_q;
	logic [VW-1:0]    v_q;

	logic [AW-1:0]    head_s;
	logic [CW-1:0]    cnt_s;
	logic [IW-1:0]    rd_idx;
	logic [VW-1:0]    rd_val;
	logic [IW-1:0]    sub_a, sub_b, diff;
	logic [IW-1:0]    cmp_a, cmp_b;
	logic             gt;

	function automatic logic [AW-1:0] qpos(input logic [AW-1:0] head,
			input logic [CW-1:0] off);
		logic [CW:0] sum;
		sum = (CW+1)'(head) + (CW+1)'(off);
		if (sum >= (CW+1)'(WINDOW_DEPTH)) begin
			sum = sum - (CW+1)'(WINDOW_DEPTH);
		end
		return sum[AW-1:0];
	endfunction

	assign head_s = head_q[sel_q];
	assign cnt_s  = count_q[sel_q];
	assign rd_idx = mem_rdata[sel_q][DW-1:VW];
	assign rd_val = mem_rdata[sel_q][VW-1:0];

	// shared unit: one subtract, feeding the one magnitude compare outside pop compare and front read
	always_comb begin
		sub_a = counter_q;
		sub_b = rd_idx;
		case (state_q)
			swps_pkg::ST_SPREAD: begin
				sub_a = IW'(mem_rdata[1][VW-1:0]);
				sub_b = IW'(mem_rdata[0][VW-1:0]);
			end
			default: begin
				sub_a = counter_q;
				sub_b = rd_idx;
			end
		endcase
	end

	assign diff = sub_a - sub_b;

	always_comb begin
		cmp_a = diff;
		cmp_b = IW'(span);
		case (state_q)
			swps_pkg::ST_POP_CMP: begin
				cmp_a = sel_q ? IW'(rd_val) : IW'(v_q);
				cmp_b = sel_q ? IW'(v_q) : IW'(rd_val);
			end
			swps_pkg::ST_FRONT_RD: begin
				cmp_a = IW'(span);
				cmp_b = counter_q;
			end
			swps_pkg::ST_SPREAD: begin
				cmp_a = diff;
				cmp_b = IW'(best_q);
			end
			default: begin
				cmp_a = diff;
				cmp_b = IW'(span);
			end
		endcase
	end

	assign gt = cmp_a > cmp_b;

	always_comb begin
		state_d      = state_q;
		sel_d        = sel_q;
		head_d       = head_q;
		count_d      = count_q;
		counter_d    = counter_q;
		wrapped_d    = wrapped_q;
		best_d       = best_q;
		mem_we       = '0;
		mem_waddr    = qpos(head_s, cnt_s);
		mem_wdata    = {counter_q, v_q};
		mem_raddr[0] = head_s;
		mem_raddr[1] = head_s;
		stat.idle    = 1'b0;
		stat.done    = 1'b0;
		case (state_q)
			swps_pkg::ST_IDLE: begin
				stat.idle = 1'b1;
				if (start) begin
					if (item.restart) begin
						head_d[0] = '0;
						head_d[1] = '0;
						count_d[0] = '0;
						count_d[1] = '0;
						counter_d = '0;
						wrapped_d = 1'b0;
						best_d    = '0;
					end
					sel_d   = 1'b0;
					state_d = swps_pkg::ST_EXP_RD;
				end
			end
			swps_pkg::ST_EXP_RD: begin
				state_d = (cnt_s == '0) ? swps_pkg::ST_POP_RD : swps_pkg::ST_EXP_CMP;
			end
			swps_pkg::ST_EXP_CMP: begin
				if (gt) begin
					head_d[sel_q]  = qpos(head_s, CW'(1));
					count_d[sel_q] = cnt_s - CW'(1);
					state_d        = swps_pkg::ST_EXP_RD;
				end else begin
					state_d = swps_pkg::ST_POP_RD;
				end
			end
			swps_pkg::ST_POP_RD: begin
				mem_raddr[0] = qpos(head_s, cnt_s - CW'(1));
				mem_raddr[1] = qpos(head_s, cnt_s - CW'(1));
				state_d = (cnt_s == '0) ? swps_pkg::ST_PUSH : swps_pkg::ST_POP_CMP;
			end
			swps_pkg::ST_POP_CMP: begin
				if (!gt) begin
					count_d[sel_q] = cnt_s - CW'(1);
					state_d        = swps_pkg::ST_POP_RD;
				end else begin
					state_d = swps_pkg::ST_PUSH;
				end
			end
			swps_pkg::ST_PUSH: begin
				mem_we[sel_q] = 1'b1;
				// full queue: oldest slot is overwritten, head moves on
				if (cnt_s == CW'(WINDOW_DEPTH)) begin
					head_d[sel_q] = qpos(head_s, CW'(1));
				end else begin
					count_d[sel_q] = cnt_s + CW'(1);
				end
				if (!sel_q) begin
					sel_d   = 1'b1;
					state_d = swps_pkg::ST_EXP_RD;
				end else begin
					state_d = swps_pkg::ST_FRONT_RD;
				end
			end
			swps_pkg::ST_FRONT_RD: begin
				mem_raddr[0] = head_q[0];
				mem_raddr[1] = head_q[1];
				state_d      = swps_pkg::ST_SPREAD;
			end
			swps_pkg::ST_SPREAD: begin
				if (full_q && gt) begin
					best_d = diff[VW-1:0];
				end
				counter_d = counter_q + IW'(1);
				if (counter_d == '0) begin
					wrapped_d = 1'b1;
				end
				state_d = swps_pkg::ST_DONE;
			end
			swps_pkg::ST_DONE: begin
				if (out_free) begin
					stat.done = 1'b1;
					state_d   = swps_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = swps_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= swps_pkg::ST_IDLE;
			sel_q      <= 1'b0;
			head_q[0]  <= '0;
			head_q[1]  <= '0;
			count_q[0] <= '0;
			count_q[1] <= '0;
			counter_q  <= '0;
			wrapped_q  <= 1'b0;
			best_q     <= '0;
		end else begin
			state_q   <= state_d;
			sel_q     <= sel_d;
			head_q    <= head_d;
			count_q   <= count_d;
			counter_q <= counter_d;
			wrapped_q <= wrapped_d;
			best_q    <= best_d;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == swps_pkg::ST_IDLE && start) begin
			v_q <= item.sample[VW-1:0];
		end
		if (state_q == swps_pkg::ST_FRONT_RD) begin
			full_q <= wrapped_q | ~gt;
		end
		if (state_q == swps_pkg::ST_SPREAD) begin
			spread_q <= diff[VW-1:0];
		end
	end

	assign result.best_spread    = FW'(best_q);
	assign result.current_spread = FW'(spread_q);
	assign result.window_full    = full_q;

	`SWPS_ASSERT_NOW(a_cnt_bound, 1'b1, (count_q[0] <= CW'(WINDOW_DEPTH)) && (count_q[1] <= CW'(WINDOW_DEPTH)), "queue count above depth")
	`SWPS_ASSERT_NOW(a_done_free, stat.done, out_free, "result done with output slot busy")
	`SWPS_ASSERT_NXT(a_push_min, (state_q == swps_pkg::ST_PUSH) && !sel_q, (count_q[0] != '0) && sel_q && (state_q == swps_pkg::ST_EXP_RD), "min push did not hand over to max queue")
	`SWPS_ASSERT_NXT(a_start_min, start && (state_q == swps_pkg::ST_IDLE), !sel_q && (state_q == swps_pkg::ST_EXP_RD), "item start did not begin on min queue")

endmodule
`default_nettype wire
